// ===== rtl/psls_pkg.sv =====
// Shared types and constants of the stylus line sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package psls_pkg;

  localparam int unsigned LineIdxBits = 16;
  localparam int unsigned LineNumW    = 16;

  localparam logic [8:0] LineEnd      = 9'd259;
  localparam logic [8:0] FirstPrinted = 9'd2;
  localparam logic [8:0] LastPrinted  = 9'd257;
  localparam logic [7:0] StopGap      = 8'd16;
  localparam logic [7:0] ResetPeriod  = 8'd25;
  localparam logic [7:0] StatusBusy   = 8'h81;
  localparam int unsigned StopBitPos   = 2;
  localparam int unsigned StylusBitPos = 7;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_BIT_PERIOD = 1'b0,
    REG_LINE_GAP   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic                pixel_valid;
    logic [7:0]          pixel_column;
    logic                pixel_black;
    logic                line_done;
    logic [LineNumW-1:0] line_number;
  } out_item_t;

  typedef struct packed {
    logic [7:0] bit_period;
    logic [7:0] line_gap;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/psls_cfg.sv =====
// Configuration registers: dot period and line gap.
// Depends on psls_pkg.
`default_nettype none

module psls_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [7:0]    cfg_wdata_i,
  output psls_pkg::cfg_t     cfg_o
);
  import psls_pkg::*;

  logic [7:0] bit_period_q;
  logic [7:0] line_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= ResetPeriod;
      line_gap_q   <= StopGap;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_BIT_PERIOD: bit_period_q <= cfg_wdata_i;
        REG_LINE_GAP:   line_gap_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  assign cfg_o.bit_period = bit_period_q;
  assign cfg_o.line_gap   = line_gap_q;

endmodule

`default_nettype wire

// ===== rtl/psls_engine.sv =====
// Printer state (motor, stylus, counters, line index) and the one-item update.
// Depends on psls_pkg.
`default_nettype none

module psls_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire psls_pkg::in_item_t item_i,
  input  wire psls_pkg::cfg_t     cfg_i,
  output psls_pkg::out_item_t result_o
);
  import psls_pkg::*;

  logic                   motor_q, motor_d;
  logic                   stylus_q, stylus_d;
  logic                   flag_q, flag_d;
  logic [7:0]             presc_q, presc_d;
  logic [7:0]             gap_q, gap_d;
  logic [8:0]             col_q, col_d;
  logic [LineIdxBits-1:0] line_q, line_d;
  logic [8:0]             col_inc;
  logic                   advance;

  assign col_inc = col_q + 9'd1;

  always_comb begin
    motor_d  = motor_q;
    stylus_d = stylus_q;
    flag_d   = flag_q;
    presc_d  = presc_q;
    gap_d    = gap_q;
    col_d    = col_q;
    advance  = 1'b0;
    result_o = '0;

    unique case (cmd_e'(item_i.command))
      CMD_TICK: begin
        if (motor_q) begin
          if (presc_q != 8'd0) begin
            presc_d = presc_q - 8'd1;
          end else begin
            presc_d = cfg_i.bit_period;
            if (gap_q != 8'd0) begin
              flag_d = 1'b0;
              gap_d  = gap_q - 8'd1;
            end else begin
              flag_d = 1'b1;
              if (col_q >= FirstPrinted && col_q <= LastPrinted) begin
                result_o.pixel_valid  = 1'b1;
                result_o.pixel_column = 8'(col_q - FirstPrinted);
                result_o.pixel_black  = stylus_q;
              end
              col_d = col_inc;
              // end of line: back to the gap
              if (col_inc == LineEnd) begin
                advance = 1'b1;
                flag_d  = 1'b0;
                col_d   = '0;
                gap_d   = cfg_i.line_gap;
              end
            end
          end
        end
      end
      CMD_WRITE: begin
        if (item_i.write_data[StopBitPos]) begin
          motor_d = 1'b0;
          advance = (col_q != 9'd0);
          col_d   = '0;
          gap_d   = StopGap;
        end else begin
          motor_d = 1'b1;
        end
        stylus_d = item_i.write_data[StylusBitPos];
        flag_d   = 1'b0;
      end
      CMD_READ: begin
        result_o.read_data = flag_q ? StatusBusy : 8'd0;
      end
      default: ;
    endcase

    line_d               = advance ? line_q + 1'b1 : line_q;
    result_o.line_done   = advance;
    result_o.line_number = LineNumW'(line_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_q  <= 1'b0;
      stylus_q <= 1'b0;
      flag_q   <= 1'b0;
      presc_q  <= ResetPeriod;
      gap_q    <= StopGap;
      col_q    <= '0;
      line_q   <= '0;
    end else if (step_i) begin
      motor_q  <= motor_d;
      stylus_q <= stylus_d;
      flag_q   <= flag_d;
      presc_q  <= presc_d;
      gap_q    <= gap_d;
      col_q    <= col_d;
      line_q   <= line_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/printer_stylus_line_sequencer_top.sv =====
// Top level of the stylus line sequencer: input register, engine, result register.
// Depends on psls_pkg, psls_cfg and psls_engine.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one command per
//   transfer: tick, port write or port read. Every accepted item yields
//   exactly one result on the output channel (out_valid_o/out_ready_i/
//   out_data_o) with read data, an optional printed dot, a line-end flag and
//   the current line number.
//   Each item passes the input register, then the result register, on its way
//   from input transfer to result transfer. Throughput: one item per cycle
//   while the receiver takes results; the engine state update is a single
//   pass of counter and compare logic.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item; after that in_ready_o drops until the
//   result is taken.
//   Configuration (bit period, line gap) is written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i while no item is in flight.
//   Reset clears both registers' valid flags, stops the motor, clears the
//   stylus and paper flag, loads prescaler 25, gap 16, column and line 0,
//   and restores the configuration to 25 and 16.
`default_nettype none

module printer_stylus_line_sequencer_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire psls_pkg::in_item_t in_data_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output psls_pkg::out_item_t out_data_o,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic [7:0]     cfg_wdata_i
);
  import psls_pkg::*;

  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  logic      step;
  cfg_t      cfg;
  out_item_t result;

  // process the held item when the result register is free or being drained
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  psls_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  psls_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .result_o(result)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

  // a dot is never printed in the same step that closes the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.pixel_valid && out_data_o.line_done))
    else $error("dot and line end in one result");

  // status byte is either zero or the busy pattern, and never with a dot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.read_data != 8'd0) |->
      (out_data_o.read_data == StatusBusy && !out_data_o.pixel_valid))
    else $error("bad status byte");

  // input may only back-pressure behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && in_vld_q))
    else $error("input stalled without output stall");

  // a stalled result must hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

// ===== dv/printer_stylus_line_sequencer_top_test.sv =====
// Self-checking test of the stylus line sequencer top level with a predicting scoreboard.
// Depends on psls_pkg and printer_stylus_line_sequencer_top; random bursts, stalls and
// register settings.
`default_nettype none

module printer_stylus_line_sequencer_top_test;
  import psls_pkg::*;

  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned HoldAfter  = 300;

  class line_scoreboard;
    logic [7:0]             bit_period;
    logic [7:0]             line_gap;
    logic                   motor_on;
    logic                   stylus;
    logic                   paper;
    logic [7:0]             prescale;
    logic [7:0]             gap_left;
    logic [8:0]             column;
    logic [LineIdxBits-1:0] line_idx;
    out_item_t              expected_q[$];
    int unsigned            errors;

    function new();
      bit_period = ResetPeriod;
      line_gap   = StopGap;
      motor_on   = 1'b0;
      stylus     = 1'b0;
      paper      = 1'b0;
      prescale   = ResetPeriod;
      gap_left   = StopGap;
      column     = '0;
      line_idx   = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [7:0] val);
      if (idx == REG_BIT_PERIOD) bit_period = val;
      else line_gap = val;
    endfunction

    function out_item_t advance_printer(in_item_t item);
      out_item_t  res;
      logic [8:0] offset;
      res = '0;
      case (item.command)
        CMD_TICK: begin
          if (motor_on) begin
            if (prescale != 0) begin
              prescale = prescale - 1'b1;
            end else begin
              prescale = bit_period;
              if (gap_left != 0) begin
                paper    = 1'b0;
                gap_left = gap_left - 1'b1;
              end else begin
                paper = 1'b1;
                if (column >= FirstPrinted && column <= LastPrinted) begin
                  offset           = column - FirstPrinted;
                  res.pixel_valid  = 1'b1;
                  res.pixel_column = offset[7:0];
                  res.pixel_black  = stylus;
                end
                column = column + 1'b1;
                if (column == LineEnd) begin
                  line_idx      = line_idx + 1'b1;
                  res.line_done = 1'b1;
                  paper         = 1'b0;
                  column        = '0;
                  gap_left      = line_gap;
                end
              end
            end
          end
        end
        CMD_WRITE: begin
          if (item.write_data[StopBitPos]) begin
            motor_on = 1'b0;
            if (column != 0) begin
              line_idx      = line_idx + 1'b1;
              res.line_done = 1'b1;
            end
            column   = '0;
            gap_left = StopGap;
          end else begin
            motor_on = 1'b1;
          end
          stylus = item.write_data[StylusBitPos];
          paper  = 1'b0;
        end
        CMD_READ: res.read_data = paper ? StatusBusy : 8'h00;
        default: ;
      endcase
      res.line_number = line_idx[LineNumW-1:0];
      return res;
    endfunction

    function void note_input(in_item_t item);
      expected_q.push_back(advance_printer(item));
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding: %0h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      cmp_field("read_data", exp_r.read_data, got.read_data);
      cmp_field("pixel_valid", exp_r.pixel_valid, got.pixel_valid);
      cmp_field("pixel_column", exp_r.pixel_column, got.pixel_column);
      cmp_field("pixel_black", exp_r.pixel_black, got.pixel_black);
      cmp_field("line_done", exp_r.line_done, got.line_done);
      cmp_field("line_number", exp_r.line_number, got.line_number);
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic       cfg_idx   = 1'b0;
  logic [7:0] cfg_wdata = '0;

  line_scoreboard sb;
  int unsigned    inputs_taken  = 0;
  int unsigned    quiet_cycles  = 0;
  bit             idle_enabled  = 1'b0;
  int unsigned    burst_left    = 0;
  bit             long_hold_done = 1'b0;
  int unsigned    hold_left     = 0;
  int unsigned    rx_mode       = 0;
  int unsigned    rx_mode_left  = 0;
  int unsigned    rx_phase      = 0;

  printer_stylus_line_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Observe transfers on both channels and guard against a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
        inputs_taken++;
      end
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL printer_stylus_line_sequencer_top");
        $finish;
      end
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off to back up the input.
  always @(negedge clk_i) begin
    if (!long_hold_done && inputs_taken >= HoldAfter) begin
      hold_left      = LongHold;
      long_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 9) != 0);
        default: out_ready <= ((rx_phase % 5) != 0);
      endcase
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    if (idle_enabled) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data);
    in_item_t item;
    item.command    = cmd;
    item.write_data = data;
    send_item(item);
  endtask

  // Drop valid and wait for every outstanding result, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly ticks with a running motor, so lines get printed; the rest reads, writes and noise.
  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned pick;
    item.write_data = 8'($urandom);
    pick = $urandom_range(0, 199);
    if (pick < 176) begin
      item.command = CMD_TICK;
    end else if (pick < 188) begin
      item.command = CMD_READ;
    end else if (pick < 194) begin
      item.command = CMD_WRITE;
      item.write_data[StopBitPos] = 1'b0;
    end else if (pick < 196) begin
      item.command = CMD_WRITE;
      item.write_data[StopBitPos] = 1'b1;
    end else if (pick < 198) begin
      item.command = CMD_WRITE;
    end else begin
      item.command = CmdUnused;
    end
    return item;
  endfunction

  task automatic run_phase(input logic [7:0] period, input logic [7:0] gap,
                           input int unsigned count, input bit idle);
    drain();
    write_reg(REG_BIT_PERIOD, period);
    write_reg(REG_LINE_GAP, gap);
    idle_enabled = idle;
    burst_left   = 0;
    repeat (count) send_item(random_item());
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, motor off, unused code, stops and starts.
    send_cmd(CMD_READ, 8'h00);
    send_cmd(CmdUnused, 8'hFF);
    send_cmd(CMD_TICK, 8'hFF);
    send_cmd(CMD_WRITE, 8'h04);
    send_cmd(CMD_WRITE, 8'h80);
    send_cmd(CMD_TICK, 8'h00);
    send_cmd(CMD_TICK, 8'h55);
    send_cmd(CMD_TICK, 8'hAA);
    send_cmd(CMD_READ, 8'hFF);
    send_cmd(CMD_WRITE, 8'h84);
    send_cmd(CMD_WRITE, 8'hFF);
    send_cmd(CMD_WRITE, 8'h7B);
    send_cmd(CMD_WRITE, 8'h00);
    send_cmd(CMD_TICK, 8'h00);

    run_phase(8'd0, 8'd0, 500, 1'b1);
    run_phase(8'd0, 8'd255, 230, 1'b0);
    run_phase(8'd255, 8'd255, 100, 1'b1);
    run_phase(8'd1, 8'd2, 200, 1'b1);
    run_phase(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)), 100, 1'b0);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS printer_stylus_line_sequencer_top");
    end else begin
      $display("FAIL printer_stylus_line_sequencer_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== printer_stylus_line_sequencer_top.f =====
rtl/psls_pkg.sv
rtl/psls_cfg.sv
rtl/psls_engine.sv
rtl/printer_stylus_line_sequencer_top.sv
dv/printer_stylus_line_sequencer_top_test.sv
